// File: rtl/dryer_mode_controller_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dryer mode controller
// Both macros expand to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef DRYER_MODE_CONTROLLER_CORE_MACROS_SVH
`define DRYER_MODE_CONTROLLER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define DMC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dmc assertion failed");
// next-cycle implication
`define DMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dmc assertion failed");
`else
`define DMC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DMC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/dmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmc_pkg
// Types, codes and constants shared by the dryer mode controller modules.
// ----------------------------------------------------------------------------
package dmc_pkg;

    localparam int HUM_W      = 14;
    localparam int SUM_W      = 16;
    localparam int TEMP_W     = 17;
    localparam int LIMIT_W    = 16;
    localparam int ABS_W      = 16;
    localparam int CMD_W      = 15;
    localparam int SP_W       = 15;
    localparam int TICKS_W    = 24;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int S_DATA_W   = 128;
    localparam int S_USER_W   = 3;
    localparam int M_DATA_W   = 56;

    localparam logic [TICKS_W-1:0] TICKS_MAX = '1;

    // floor(x/3) == (x * 43691) >> 17 for every x below 2^17
    localparam logic [15:0] RECIP3       = 16'd43691;
    localparam int          RECIP3_SHIFT = 17;

    typedef enum logic [2:0] {
        MODE_IDLE      = 3'd0,
        MODE_TUNING    = 3'd1,
        MODE_DRYING    = 3'd2,
        MODE_VENTING   = 3'd3,
        MODE_EMERGENCY = 3'd4,
        MODE_MANUAL    = 3'd5,
        MODE_SHOWCASE  = 3'd6
    } mode_t;

    typedef enum logic [2:0] {
        REQ_TICK      = 3'd0,
        REQ_SET_MODE  = 3'd1,
        REQ_SETPOINT  = 3'd2,
        REQ_FAN       = 3'd3,
        REQ_VENTS     = 3'd4,
        REQ_TUNE_DONE = 3'd5
    } req_t;

    localparam logic [2:0] REG_TARGET_TEMP = 3'd0;
    localparam logic [2:0] REG_MAX_FIL     = 3'd1;
    localparam logic [2:0] REG_TARGET_HUM  = 3'd2;
    localparam logic [2:0] REG_VENT_INTVL  = 3'd3;
    localparam logic [2:0] REG_SHOWCASE    = 3'd4;

    localparam logic [13:0] RST_TARGET_TEMP = 14'd5000;
    localparam logic [15:0] RST_MAX_FIL     = 16'd7000;
    localparam logic [13:0] RST_TARGET_HUM  = 14'd2000;
    localparam logic [23:0] RST_VENT_INTVL  = 24'd30000;

    typedef struct packed {
        logic [13:0]        target_chamber_temp;
        logic [LIMIT_W-1:0] max_filament_temp;
        logic [13:0]        target_rel_hum;
        logic [TICKS_W-1:0] vent_interval;
        logic               showcase_enable;
    } cfg_t;

    // one accepted transaction, with the humidity sum and filament max precomputed
    typedef struct packed {
        logic [2:0]              req;
        logic [SUM_W-1:0]        hum_sum;
        logic signed [TEMP_W-1:0] fil_max;
        logic [ABS_W-1:0]        int_abs;
        logic [ABS_W-1:0]        ext_abs;
        logic [CMD_W-1:0]        cmd_value;
    } item_t;

    typedef struct packed {
        mode_t                    mode;
        logic [SP_W-1:0]          heater_setpoint;
        logic                     fan_on;
        logic                     vents_open;
        logic                     tune_request;
        logic [HUM_W-1:0]         avg_chamber_hum;
        logic signed [TEMP_W-1:0] max_filament;
    } res_t;

endpackage

// File: rtl/dmc_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmc_cfg
// APB register file holding the controller settings.
// ----------------------------------------------------------------------------
module dmc_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dmc_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [dmc_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [dmc_pkg::CFG_DATA_W-1:0]  prdata,
    output dmc_pkg::cfg_t                   cfg
);

    dmc_pkg::cfg_t cfg_reg;
    logic          wr_en;
    logic [2:0]    reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_chamber_temp <= dmc_pkg::RST_TARGET_TEMP;
            cfg_reg.max_filament_temp   <= dmc_pkg::RST_MAX_FIL;
            cfg_reg.target_rel_hum      <= dmc_pkg::RST_TARGET_HUM;
            cfg_reg.vent_interval       <= dmc_pkg::RST_VENT_INTVL;
            cfg_reg.showcase_enable     <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_idx)
                dmc_pkg::REG_TARGET_TEMP: cfg_reg.target_chamber_temp <= pwdata[13:0];
                dmc_pkg::REG_MAX_FIL:     cfg_reg.max_filament_temp   <= pwdata[15:0];
                dmc_pkg::REG_TARGET_HUM:  cfg_reg.target_rel_hum      <= pwdata[13:0];
                dmc_pkg::REG_VENT_INTVL:  cfg_reg.vent_interval       <= pwdata[23:0];
                dmc_pkg::REG_SHOWCASE:    cfg_reg.showcase_enable     <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            dmc_pkg::REG_TARGET_TEMP: prdata = {18'd0, cfg_reg.target_chamber_temp};
            dmc_pkg::REG_MAX_FIL:     prdata = {16'd0, cfg_reg.max_filament_temp};
            dmc_pkg::REG_TARGET_HUM:  prdata = {18'd0, cfg_reg.target_rel_hum};
            dmc_pkg::REG_VENT_INTVL:  prdata = {8'd0, cfg_reg.vent_interval};
            dmc_pkg::REG_SHOWCASE:    prdata = {31'd0, cfg_reg.showcase_enable};
            default:                  prdata = '0;
        endcase
    end

endmodule

// File: rtl/dmc_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmc_prep
// Input register: unpacks a transaction and forms humidity sum and filament max.
// ----------------------------------------------------------------------------
module dmc_prep (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [dmc_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic [dmc_pkg::S_USER_W-1:0]  s_tuser,
    input  logic                          take,
    output logic                          item_valid,
    output dmc_pkg::item_t                item
);

    logic                               in_valid_reg;
    logic                               in_valid_next;
    dmc_pkg::item_t                     item_reg;
    dmc_pkg::item_t                     item_next;
    logic [dmc_pkg::HUM_W-1:0]          hum_a;
    logic [dmc_pkg::HUM_W-1:0]          hum_b;
    logic [dmc_pkg::HUM_W-1:0]          hum_c;
    logic signed [dmc_pkg::TEMP_W-1:0]  fil_a;
    logic signed [dmc_pkg::TEMP_W-1:0]  fil_b;
    logic                               accept;

    assign s_tready   = !in_valid_reg || take;
    assign accept     = s_tvalid && s_tready;
    assign item_valid = in_valid_reg;
    assign item       = item_reg;

    assign hum_a = s_tdata[13:0];
    assign hum_b = s_tdata[27:14];
    assign hum_c = s_tdata[41:28];
    assign fil_a = s_tdata[58:42];
    assign fil_b = s_tdata[75:59];

    always_comb begin
        item_next.req       = s_tuser;
        item_next.hum_sum   = {2'b00, hum_a} + {2'b00, hum_b} + {2'b00, hum_c};
        item_next.fil_max   = (fil_a > fil_b) ? fil_a : fil_b;
        item_next.int_abs   = s_tdata[91:76];
        item_next.ext_abs   = s_tdata[107:92];
        item_next.cmd_value = s_tdata[122:108];
    end

    always_comb begin
        if (accept) begin
            in_valid_next = 1'b1;
        end else if (take) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= item_next;
        end
    end

endmodule

// File: rtl/dmc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmc_ctrl
// Mode machine, actuator state and result register.
// ----------------------------------------------------------------------------
`include "dryer_mode_controller_core_macros.svh"

module dmc_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  dmc_pkg::cfg_t   cfg,
    input  logic            item_valid,
    input  dmc_pkg::item_t  item,
    output logic            take,
    output logic            m_tvalid,
    input  logic            m_tready,
    output dmc_pkg::res_t   res
);

    dmc_pkg::mode_t                     cur_mode_reg,  cur_mode_next;
    dmc_pkg::mode_t                     prev_mode_reg, prev_mode_next;
    logic [dmc_pkg::TICKS_W-1:0]        vent_ticks_reg, vent_ticks_next;
    logic [dmc_pkg::SP_W-1:0]           setpoint_reg, setpoint_next;
    logic                               fan_reg, fan_next;
    logic                               vents_reg, vents_next;
    logic                               tune_done_reg, tune_done_next;
    logic [dmc_pkg::HUM_W-1:0]          avg_hum_reg, avg_hum_next;
    logic signed [dmc_pkg::TEMP_W-1:0]  max_fil_reg, max_fil_next;
    logic                               out_valid_reg, out_valid_next;
    dmc_pkg::res_t                      res_reg, res_next;

    logic                               pulse;
    logic                               entering;
    logic                               too_hot;
    logic                               hum_high;
    logic                               vent_done;
    logic [dmc_pkg::SUM_W-1:0]          goal3;
    logic [31:0]                        quot_prod;
    logic [dmc_pkg::TICKS_W-1:0]        ticks_inc;
    logic [dmc_pkg::SP_W-1:0]           sp_target;
    dmc_pkg::mode_t                     rest_idle;
    dmc_pkg::mode_t                     rest_drying;

    assign take     = item_valid && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign res      = res_reg;

    assign goal3     = {1'b0, cfg.target_rel_hum, 1'b0} + {2'b00, cfg.target_rel_hum};
    assign hum_high  = item.hum_sum > goal3;
    assign too_hot   = $signed({item.fil_max[dmc_pkg::TEMP_W-1], item.fil_max})
                       > $signed({2'b00, cfg.max_filament_temp});
    assign quot_prod = 32'(item.hum_sum) * 32'(dmc_pkg::RECIP3);
    assign ticks_inc = (vent_ticks_reg == dmc_pkg::TICKS_MAX) ? vent_ticks_reg
                       : vent_ticks_reg + 1'b1;
    assign vent_done = ticks_inc >= cfg.vent_interval;
    assign entering  = prev_mode_reg != cur_mode_reg;
    assign sp_target = {1'b0, cfg.target_chamber_temp};
    assign rest_idle   = cfg.showcase_enable ? dmc_pkg::MODE_SHOWCASE : dmc_pkg::MODE_IDLE;
    assign rest_drying = cfg.showcase_enable ? dmc_pkg::MODE_SHOWCASE : dmc_pkg::MODE_DRYING;

    always_comb begin
        cur_mode_next   = cur_mode_reg;
        prev_mode_next  = prev_mode_reg;
        vent_ticks_next = vent_ticks_reg;
        setpoint_next   = setpoint_reg;
        fan_next        = fan_reg;
        vents_next      = vents_reg;
        tune_done_next  = tune_done_reg;
        avg_hum_next    = avg_hum_reg;
        max_fil_next    = max_fil_reg;
        pulse           = 1'b0;

        unique case (item.req)
            dmc_pkg::REQ_TICK: begin
                avg_hum_next    = quot_prod[dmc_pkg::RECIP3_SHIFT +: dmc_pkg::HUM_W];
                max_fil_next    = item.fil_max;
                vent_ticks_next = ticks_inc;
                prev_mode_next  = cur_mode_reg;
                unique case (cur_mode_reg)
                    dmc_pkg::MODE_IDLE, dmc_pkg::MODE_SHOWCASE: begin
                        setpoint_next = '0;
                        fan_next      = 1'b0;
                        vents_next    = 1'b0;
                        if (hum_high) begin
                            cur_mode_next = dmc_pkg::MODE_DRYING;
                        end
                    end
                    dmc_pkg::MODE_TUNING: begin
                        if (entering) begin
                            setpoint_next = sp_target;
                            pulse         = 1'b1;
                        end
                        if (tune_done_reg) begin
                            tune_done_next = 1'b0;
                            cur_mode_next  = rest_idle;
                        end
                    end
                    dmc_pkg::MODE_DRYING: begin
                        if (too_hot) begin
                            cur_mode_next = dmc_pkg::MODE_EMERGENCY;
                        end else begin
                            setpoint_next = sp_target;
                            fan_next      = 1'b1;
                            if (item.int_abs > item.ext_abs) begin
                                cur_mode_next = dmc_pkg::MODE_VENTING;
                            end else if (!hum_high) begin
                                cur_mode_next = rest_idle;
                            end
                        end
                    end
                    dmc_pkg::MODE_VENTING: begin
                        setpoint_next = '0;
                        fan_next      = !vent_done;
                        vents_next    = !vent_done;
                        if (vent_done) begin
                            cur_mode_next   = dmc_pkg::MODE_DRYING;
                            vent_ticks_next = '0;
                        end
                    end
                    dmc_pkg::MODE_EMERGENCY: begin
                        setpoint_next = '0;
                        fan_next      = too_hot;
                        vents_next    = too_hot;
                        if (!too_hot) begin
                            cur_mode_next = rest_drying;
                        end
                    end
                    dmc_pkg::MODE_MANUAL: ;
                    default: begin
                        prev_mode_next = dmc_pkg::MODE_IDLE;
                        cur_mode_next  = dmc_pkg::MODE_IDLE;
                    end
                endcase
            end
            dmc_pkg::REQ_SET_MODE: begin
                if (item.cmd_value <= dmc_pkg::CMD_W'(dmc_pkg::MODE_SHOWCASE)) begin
                    cur_mode_next = dmc_pkg::mode_t'(item.cmd_value[2:0]);
                end
            end
            dmc_pkg::REQ_SETPOINT: begin
                cur_mode_next = dmc_pkg::MODE_MANUAL;
                setpoint_next = item.cmd_value;
            end
            dmc_pkg::REQ_FAN: begin
                cur_mode_next = dmc_pkg::MODE_MANUAL;
                fan_next      = |item.cmd_value;
            end
            dmc_pkg::REQ_VENTS: begin
                cur_mode_next = dmc_pkg::MODE_MANUAL;
                vents_next    = |item.cmd_value;
            end
            dmc_pkg::REQ_TUNE_DONE: begin
                tune_done_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        res_next.mode            = cur_mode_next;
        res_next.heater_setpoint = setpoint_next;
        res_next.fan_on          = fan_next;
        res_next.vents_open      = vents_next;
        res_next.tune_request    = pulse;
        res_next.avg_chamber_hum = avg_hum_next;
        res_next.max_filament    = max_fil_next;
        if (take) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_mode_reg   <= dmc_pkg::MODE_IDLE;
            prev_mode_reg  <= dmc_pkg::MODE_IDLE;
            vent_ticks_reg <= '0;
            setpoint_reg   <= '0;
            fan_reg        <= 1'b0;
            vents_reg      <= 1'b0;
            tune_done_reg  <= 1'b0;
            avg_hum_reg    <= '0;
            max_fil_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (take) begin
                cur_mode_reg   <= cur_mode_next;
                prev_mode_reg  <= prev_mode_next;
                vent_ticks_reg <= vent_ticks_next;
                setpoint_reg   <= setpoint_next;
                fan_reg        <= fan_next;
                vents_reg      <= vents_next;
                tune_done_reg  <= tune_done_next;
                avg_hum_reg    <= avg_hum_next;
                max_fil_reg    <= max_fil_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            res_reg <= res_next;
        end
    end

    // venting that hands back to drying restarts the tick count
    `DMC_ASSERT_NEXT(a_vent_clear, aclk, aresetn, take && item.req == dmc_pkg::REQ_TICK && cur_mode_reg == dmc_pkg::MODE_VENTING && cur_mode_next == dmc_pkg::MODE_DRYING, vent_ticks_reg == '0)
    // commands never touch the tuning-entry history
    `DMC_ASSERT_NEXT(a_cmd_prev, aclk, aresetn, take && item.req != dmc_pkg::REQ_TICK, $stable(prev_mode_reg))
    // a tune request goes out with the drying setpoint applied
    `DMC_ASSERT_NEXT(a_tune_sp, aclk, aresetn, take && pulse, res_reg.heater_setpoint == $past(sp_target))
    // the result register reflects the stored actuator state
    `DMC_ASSERT_IMP(a_res_state, aclk, aresetn, out_valid_reg, res_reg.mode == cur_mode_reg && res_reg.fan_on == fan_reg && res_reg.vents_open == vents_reg)

endmodule

// File: rtl/dryer_mode_controller_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dryer_mode_controller_core
// Mode controller of a drying chamber: stream in ticks/commands, stream out state.
// ----------------------------------------------------------------------------
// An accepted transaction passes the input register, then the result register.
// Throughput: 1 transaction per cycle while m_tready is high; input and result
//   registers decouple the sides, state updates in one pass of compare logic.
// Reset: aresetn synchronous, active low; mode idle, actuators off, counters
//   zero, settings at their defaults, both channels empty.
module dryer_mode_controller_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    // humidity a, b, c (14 each), filament temp a, b (17 each, signed),
    // interior abs hum (16), exterior abs hum (16), cmd_value (15), zero pad
    input  logic [dmc_pkg::S_DATA_W-1:0]    s_tdata,
    // req_type (3)
    input  logic [dmc_pkg::S_USER_W-1:0]    s_tuser,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // mode (3), heater_setpoint (15), fan_on, vents_open, tune_request,
    // avg_chamber_hum (14), max_filament (17, signed), zero pad
    output logic [dmc_pkg::M_DATA_W-1:0]    m_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dmc_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [dmc_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [dmc_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready
);

    dmc_pkg::cfg_t  cfg;
    dmc_pkg::item_t item;
    dmc_pkg::res_t  res;
    logic           item_valid;
    logic           take;

    assign pready = 1'b1;

    dmc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    dmc_prep u_prep (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    dmc_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .res        (res)
    );

    assign m_tdata = {4'd0, res.max_filament, res.avg_chamber_hum, res.tune_request,
                      res.vents_open, res.fan_on, res.heater_setpoint, res.mode};

endmodule

// File: bench/dmc_status_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmc_status_checker
// Watches the input, result and APB ports of the dryer mode controller. Each
// accepted input transaction is run through a local model of the mode machine
// and queued; each accepted result is compared field by field with the oldest
// queued status. Reports the mismatch count and the number of results owed.
// ----------------------------------------------------------------------------
module dmc_status_checker
    import dmc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic [S_USER_W-1:0]   s_tuser,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    input  logic                  pready,
    output int                    mismatch_count,
    output int                    pending_results
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [2:0]               mode;
        logic [SP_W-1:0]          setpoint;
        logic                     fan;
        logic                     vents;
        logic                     tune;
        logic [HUM_W-1:0]         avg_hum;
        logic signed [TEMP_W-1:0] max_fil;
    } status_t;

    // settings as last written over APB
    logic [13:0]        set_target_temp;
    logic [LIMIT_W-1:0] set_max_fil;
    logic [13:0]        set_target_hum;
    logic [TICKS_W-1:0] set_vent_intvl;
    logic               set_showcase;

    // controller state
    mode_t                    mode_now;
    mode_t                    mode_prev;
    logic [TICKS_W-1:0]       tick_count;
    logic [SP_W-1:0]          heater_sp;
    logic                     fan_drive;
    logic                     vent_drive;
    logic                     tune_finished;
    logic [HUM_W-1:0]         avg_hum_held;
    logic signed [TEMP_W-1:0] max_fil_held;

    status_t expected_status[$];

    function automatic mode_t resting(input mode_t otherwise);
        return set_showcase ? MODE_SHOWCASE : otherwise;
    endfunction

    function automatic status_t advance_controller(input logic [2:0] req,
                                                   input logic [S_DATA_W-1:0] d);
        logic [CMD_W-1:0] val;
        logic [ABS_W-1:0] int_abs;
        logic [ABS_W-1:0] ext_abs;
        int               hum_total;
        int               goal3;
        int               fil_a;
        int               fil_b;
        int               fil_max;
        logic             entering;
        logic             too_hot;
        logic             pulse;
        status_t          r;
        val   = d[122:108];
        pulse = 1'b0;
        case (req)
            REQ_TICK: begin
                hum_total = int'(d[13:0]) + int'(d[27:14]) + int'(d[41:28]);
                fil_a     = int'($signed(d[58:42]));
                fil_b     = int'($signed(d[75:59]));
                int_abs   = d[91:76];
                ext_abs   = d[107:92];
                // exact sum against 3x goal, so the floored average never decides
                goal3     = 3 * int'(set_target_hum);
                fil_max   = (fil_a > fil_b) ? fil_a : fil_b;
                too_hot   = fil_max > int'(set_max_fil);
                avg_hum_held = HUM_W'(hum_total / 3);
                max_fil_held = TEMP_W'(fil_max);
                if (tick_count != TICKS_MAX) begin
                    tick_count = tick_count + 1'b1;
                end
                entering  = mode_prev != mode_now;
                mode_prev = mode_now;
                case (mode_now)
                    MODE_IDLE, MODE_SHOWCASE: begin
                        heater_sp  = '0;
                        fan_drive  = 1'b0;
                        vent_drive = 1'b0;
                        if (hum_total > goal3) begin
                            mode_now = MODE_DRYING;
                        end
                    end
                    MODE_TUNING: begin
                        if (entering) begin
                            heater_sp = SP_W'(set_target_temp);
                            pulse     = 1'b1;
                        end
                        if (tune_finished) begin
                            tune_finished = 1'b0;
                            mode_now      = resting(MODE_IDLE);
                        end
                    end
                    MODE_DRYING: begin
                        if (too_hot) begin
                            mode_now = MODE_EMERGENCY;
                        end else begin
                            heater_sp = SP_W'(set_target_temp);
                            fan_drive = 1'b1;
                            if (int_abs > ext_abs) begin
                                mode_now = MODE_VENTING;
                            end else if (hum_total <= goal3) begin
                                mode_now = resting(MODE_IDLE);
                            end
                        end
                    end
                    MODE_VENTING: begin
                        heater_sp  = '0;
                        fan_drive  = 1'b1;
                        vent_drive = 1'b1;
                        // counter runs in every mode, so this may end at once
                        if (tick_count >= set_vent_intvl) begin
                            fan_drive  = 1'b0;
                            vent_drive = 1'b0;
                            mode_now   = MODE_DRYING;
                            tick_count = '0;
                        end
                    end
                    MODE_EMERGENCY: begin
                        heater_sp  = '0;
                        fan_drive  = 1'b1;
                        vent_drive = 1'b1;
                        if (!too_hot) begin
                            fan_drive  = 1'b0;
                            vent_drive = 1'b0;
                            mode_now   = resting(MODE_DRYING);
                        end
                    end
                    MODE_MANUAL: ;
                    default: begin
                        mode_prev = MODE_IDLE;
                        mode_now  = MODE_IDLE;
                    end
                endcase
            end
            REQ_SET_MODE: begin
                if (val <= CMD_W'(MODE_SHOWCASE)) begin
                    mode_now = mode_t'(val[2:0]);
                end
            end
            REQ_SETPOINT: begin
                mode_now  = MODE_MANUAL;
                heater_sp = val;
            end
            REQ_FAN: begin
                mode_now  = MODE_MANUAL;
                fan_drive = val != '0;
            end
            REQ_VENTS: begin
                mode_now   = MODE_MANUAL;
                vent_drive = val != '0;
            end
            REQ_TUNE_DONE: tune_finished = 1'b1;
            default: ;
        endcase
        r.mode     = mode_now;
        r.setpoint = heater_sp;
        r.fan      = fan_drive;
        r.vents    = vent_drive;
        r.tune     = pulse;
        r.avg_hum  = avg_hum_held;
        r.max_fil  = max_fil_held;
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        status_t got;
        status_t want;
        if (!aresetn) begin
            set_target_temp = RST_TARGET_TEMP;
            set_max_fil     = RST_MAX_FIL;
            set_target_hum  = RST_TARGET_HUM;
            set_vent_intvl  = RST_VENT_INTVL;
            set_showcase    = 1'b0;
            mode_now        = MODE_IDLE;
            mode_prev       = MODE_IDLE;
            tick_count      = '0;
            heater_sp       = '0;
            fan_drive       = 1'b0;
            vent_drive      = 1'b0;
            tune_finished   = 1'b0;
            avg_hum_held    = '0;
            max_fil_held    = '0;
            mismatch_count  = 0;
            expected_status.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_TARGET_TEMP: set_target_temp = pwdata[13:0];
                    REG_MAX_FIL:     set_max_fil     = pwdata[LIMIT_W-1:0];
                    REG_TARGET_HUM:  set_target_hum  = pwdata[13:0];
                    REG_VENT_INTVL:  set_vent_intvl  = pwdata[TICKS_W-1:0];
                    REG_SHOWCASE:    set_showcase    = pwdata[0];
                    default: ;
                endcase
            end
            // results first: a result never belongs to the transaction taken this edge
            if (m_tvalid && m_tready) begin
                got.mode     = m_tdata[2:0];
                got.setpoint = m_tdata[17:3];
                got.fan      = m_tdata[18];
                got.vents    = m_tdata[19];
                got.tune     = m_tdata[20];
                got.avg_hum  = m_tdata[34:21];
                got.max_fil  = m_tdata[51:35];
                if (expected_status.size() == 0) begin
                    if (mismatch_count < REPORT_LIMIT) begin
                        $display("%0t: result with nothing expected: mode=%0d sp=%0d",
                                 $realtime, got.mode, got.setpoint);
                    end
                    mismatch_count++;
                end else begin
                    want = expected_status.pop_front();
                    if (got.mode !== want.mode || got.setpoint !== want.setpoint ||
                        got.fan !== want.fan || got.vents !== want.vents ||
                        got.tune !== want.tune || got.avg_hum !== want.avg_hum ||
                        got.max_fil !== want.max_fil) begin
                        if (mismatch_count < REPORT_LIMIT) begin
                            $display("%0t: status mismatch", $realtime);
                            $display("  exp mode=%0d sp=%0d fan=%0b vents=%0b tune=%0b avg=%0d max=%0d",
                                     want.mode, want.setpoint, want.fan, want.vents,
                                     want.tune, want.avg_hum, want.max_fil);
                            $display("  got mode=%0d sp=%0d fan=%0b vents=%0b tune=%0b avg=%0d max=%0d",
                                     got.mode, got.setpoint, got.fan, got.vents,
                                     got.tune, got.avg_hum, got.max_fil);
                        end
                        mismatch_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_status.push_back(advance_controller(s_tuser, s_tdata));
            end
        end
        pending_results <= expected_status.size();
    end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the dryer mode controller. A directed walk through
// the mode transitions and every command is followed by six randomized phases,
// each with its own register settings and one of three backpressure patterns.
// Checking is done by dmc_status_checker, which sits beside the block.
// ----------------------------------------------------------------------------
module testbench;
    import dmc_pkg::*;

    localparam logic [2:0]       REQ_RESERVED_A    = 3'd6;
    localparam logic [2:0]       REQ_RESERVED_B    = 3'd7;
    localparam logic [CMD_W-1:0] MODE_CODE_INVALID = 15'd7;
    localparam int               PHASE_ITEMS       = 160;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic [S_DATA_W-1:0]   s_tdata  = '0;
    logic [S_USER_W-1:0]   s_tuser  = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [CFG_DATA_W-1:0] pwdata   = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    int                    mismatch_count;
    int                    pending_results;

    int                    tx_idle_pct  = 0;
    int                    rx_stall_pct = 0;
    logic [13:0]           cfg_target_hum = RST_TARGET_HUM;
    logic [LIMIT_W-1:0]    cfg_max_fil    = RST_MAX_FIL;

    dryer_mode_controller_core dut (.*);
    dmc_status_checker checker_i (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    function automatic logic [S_DATA_W-1:0] pack_fields(
        input logic [HUM_W-1:0] ha, input logic [HUM_W-1:0] hb, input logic [HUM_W-1:0] hc,
        input logic [TEMP_W-1:0] fa, input logic [TEMP_W-1:0] fb,
        input logic [ABS_W-1:0] ai, input logic [ABS_W-1:0] ae, input logic [CMD_W-1:0] val);
        return S_DATA_W'({val, ae, ai, fb, fa, hc, hb, ha});
    endfunction

    task automatic send_item(input logic [2:0] req, input logic [S_DATA_W-1:0] data);
        logic hs;
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= data;
        // ready is sampled at the falling edge ahead of the edge it applies to
        do begin
            @(negedge aclk);
            hs = s_tready;
            @(posedge aclk);
        end while (!hs);
    endtask

    // commands carry noise in the sensor fields, which must be ignored
    task automatic send_cmd(input logic [2:0] req, input logic [CMD_W-1:0] val);
        send_item(req, pack_fields(HUM_W'($urandom), HUM_W'($urandom), HUM_W'($urandom),
                                   TEMP_W'($urandom), TEMP_W'($urandom),
                                   ABS_W'($urandom), ABS_W'($urandom), val));
    endtask

    task automatic send_tick(input int ha, input int hb, input int hc, input int fa,
                             input int fb, input int ai, input int ae);
        send_item(REQ_TICK, pack_fields(HUM_W'(ha), HUM_W'(hb), HUM_W'(hc), TEMP_W'(fa),
                                        TEMP_W'(fb), ABS_W'(ai), ABS_W'(ae),
                                        CMD_W'($urandom)));
    endtask

    task automatic wait_drained();
        do @(negedge aclk); while (pending_results != 0);
        @(posedge aclk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] value);
        logic ok;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do begin
            @(negedge aclk);
            ok = pready;
            @(posedge aclk);
        end while (!ok);
    endtask

    task automatic program_settings(input logic [31:0] temp_v, input logic [31:0] fil_v,
                                    input logic [31:0] hum_v, input logic [31:0] intvl_v,
                                    input logic [31:0] show_v);
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (4) @(posedge aclk);
        write_register(REG_TARGET_TEMP, temp_v);
        write_register(REG_MAX_FIL, fil_v);
        write_register(REG_TARGET_HUM, hum_v);
        write_register(REG_VENT_INTVL, intvl_v);
        write_register(REG_SHOWCASE, show_v);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_target_hum = hum_v[13:0];
        cfg_max_fil    = fil_v[LIMIT_W-1:0];
    endtask

    function automatic int pick_humidity();
        int roll;
        int v;
        roll = $urandom_range(99);
        if (roll < 70) begin
            v = int'(cfg_target_hum) + int'($urandom_range(600)) - 300;
            if (v < 0) v = 0;
            if (v > 16383) v = 16383;
        end else if (roll < 90) begin
            v = $urandom_range(10000);
        end else begin
            v = $urandom_range(16383);
        end
        return v;
    endfunction

    function automatic int pick_temperature();
        int roll;
        roll = $urandom_range(99);
        if (roll < 50) return $urandom_range(cfg_max_fil);
        if (roll < 80) return int'(cfg_max_fil) + int'($urandom_range(600)) - 300;
        if (roll < 90) return int'($urandom_range(42000)) - 4000;
        return $urandom;
    endfunction

    task automatic send_random_item();
        int roll;
        int ext_abs;
        int int_abs;
        roll = $urandom_range(99);
        if (roll < 81) begin
            ext_abs = $urandom_range(65535);
            int_abs = ($urandom_range(99) < 60) ? $urandom_range(ext_abs) : $urandom_range(65535);
            send_tick(pick_humidity(), pick_humidity(), pick_humidity(),
                      pick_temperature(), pick_temperature(), int_abs, ext_abs);
        end else if (roll < 87) begin
            send_cmd(REQ_SET_MODE, ($urandom_range(4) == 0) ? CMD_W'($urandom)
                                                            : CMD_W'($urandom_range(7)));
        end else if (roll < 92) begin
            send_cmd(REQ_TUNE_DONE, CMD_W'($urandom));
        end else if (roll < 95) begin
            send_cmd(REQ_SETPOINT, CMD_W'($urandom));
        end else if (roll < 97) begin
            send_cmd(REQ_FAN, $urandom_range(1) ? CMD_W'($urandom) : '0);
        end else if (roll < 99) begin
            send_cmd(REQ_VENTS, $urandom_range(1) ? CMD_W'($urandom) : '0);
        end else begin
            send_cmd($urandom_range(1) ? REQ_RESERVED_A : REQ_RESERVED_B, CMD_W'($urandom));
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed walk: short vent interval so venting can end
        program_settings(5000, 7000, 2000, 2, 0);
        send_cmd(REQ_SET_MODE, MODE_CODE_INVALID);
        send_cmd(REQ_RESERVED_A, CMD_W'($urandom));
        send_cmd(REQ_RESERVED_B, CMD_W'($urandom));
        send_tick(0, 0, 0, -65536, -4000, 0, 0);
        send_tick(16383, 16383, 16383, 65535, -65536, 0, 65535);
        send_tick(16383, 16383, 16383, 65535, 0, 0, 65535);       // too hot
        send_tick(16383, 16383, 16383, 65535, 7001, 0, 65535);    // still hot
        send_tick(16383, 16383, 16383, 7000, -1, 0, 65535);       // cooled at limit
        send_tick(16383, 16383, 16383, 100, 100, 65535, 0);       // wetter inside
        send_tick(16383, 16383, 16383, 100, 100, 65535, 0);       // stale count ends at once
        send_tick(16383, 16383, 16383, 100, 100, 1, 0);
        send_tick(16383, 16383, 16383, 100, 100, 0, 0);
        send_tick(2000, 2000, 2000, 100, 100, 0, 0);              // goal reached exactly
        send_tick(2001, 2000, 2000, 100, 100, 0, 0);              // one above goal
        send_cmd(REQ_SET_MODE, CMD_W'(MODE_TUNING));
        send_tick(0, 0, 0, 0, 0, 0, 0);                           // tuning entry pulse
        send_tick(0, 0, 0, 0, 0, 0, 0);
        send_cmd(REQ_TUNE_DONE, '0);
        send_tick(0, 0, 0, 0, 0, 0, 0);
        send_cmd(REQ_SETPOINT, '1);
        send_cmd(REQ_FAN, 15'd5);
        send_cmd(REQ_VENTS, '1);
        send_cmd(REQ_VENTS, '0);
        send_tick(9000, 9000, 9000, 9000, 9000, 9000, 0);
        send_cmd(REQ_SET_MODE, CMD_W'(MODE_SHOWCASE));
        send_tick(9000, 9000, 9000, 100, 100, 0, 9000);

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: program_settings(5000, 7000, 2000, 5, 0);
                1: program_settings(0, 0, 0, 0, 0);
                2: program_settings(14'h3FFF, 16'hFFFF, 14'h3FFF, 24'hFFFFFF, 1);
                3: program_settings($urandom_range(12000), $urandom_range(38000),
                                    $urandom_range(10000), $urandom_range(20),
                                    $urandom_range(1));
                4: program_settings($urandom, $urandom, {18'($urandom), 14'($urandom_range(10000))},
                                    {8'($urandom), 24'($urandom_range(40))}, $urandom);
                default: program_settings(12000, 38000, 10000, 1, 1);
            endcase
            case (p % 3)
                0: begin tx_idle_pct = 25; rx_stall_pct = 51; end
                1: begin tx_idle_pct = 51; rx_stall_pct = 25; end
                default: begin tx_idle_pct = 0; rx_stall_pct = 0; end
            endcase
            repeat (PHASE_ITEMS) send_random_item();
        end

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        if (mismatch_count == 0 && pending_results == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
